// ===== design/rwf_pkg.sv =====
`timescale 1ns / 1ps

package rwf_pkg;

	localparam int RING_ENTRIES = 4096;
	localparam int IDX_W = $clog2(RING_ENTRIES);
	localparam int CNT_W = $clog2(RING_ENTRIES + 1);

	localparam int KEY_W = 64;
	localparam int TIME_W = 40;
	localparam int TTL_W = 16;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [TTL_W-1:0] TTL_RESET = 16'd400;

	typedef struct packed {
		logic [KEY_W-1:0] word3;
		logic [KEY_W-1:0] word2;
		logic [KEY_W-1:0] word1;
		logic [KEY_W-1:0] word0;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== design/rwf_ram.sv =====
`timescale 1ns / 1ps

module rwf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/replay_window_filter_core.sv =====
`timescale 1ns / 1ps

// Replay filter over a ring of stored 256-bit keys with a time-to-live. Each item is checked
// against every ring entry, one entry per cycle through the single read port of the ring
// memory, and is accepted and stored at the ring pointer unless a live entry holds the same
// key. No new item is taken until the scan and the finishing step of the last one are done;
// the scan over the memory read port takes most of that time. The result sits in an output
// register, so the next item can be taken while it waits. Slots that have never been written
// read as key zero at time zero through a fill count, so there is no clearing pass after
// reset. The ttl_seconds register lies at address 0.
module replay_window_filter_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [rwf_pkg::KEY_W-1:0]            key_word0,
	input  logic [rwf_pkg::KEY_W-1:0]            key_word1,
	input  logic [rwf_pkg::KEY_W-1:0]            key_word2,
	input  logic [rwf_pkg::KEY_W-1:0]            key_word3,
	input  logic [rwf_pkg::TIME_W-1:0]           now_seconds,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 accepted,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [rwf_pkg::APB_ADDR_W-1:0]       paddr,
	input  logic [rwf_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [rwf_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                 pready
);

	import rwf_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_ENTRIES - 1);
	localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(RING_ENTRIES);

	logic [1:0]        state_q;
	logic [TTL_W-1:0]  ttl_q;
	entry_t            item_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic [IDX_W-1:0]  wp_q;
	logic [CNT_W-1:0]  fill_q;
	logic              hit_q;
	logic              rd_valid_s1;
	logic              rd_filled_s1;
	logic              out_valid_q;
	logic              accepted_q;

	logic              in_take;
	logic              out_free;
	logic              ram_we;
	logic              ram_re;
	entry_t            ram_rdata;
	entry_t            entry;
	logic              key_eq;
	logic              entry_live;
	logic [TIME_W-1:0] age;
	logic              entry_hit;
	logic              cfg_wr;

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign ram_re   = (state_q == ST_SCAN);
	assign ram_we   = (state_q == ST_DONE) && out_free && !hit_q;

	rwf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (RING_ENTRIES)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (item_q),
		.re    (ram_re),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		entry      = rd_filled_s1 ? ram_rdata : '0;
		key_eq     = (entry.word0 == item_q.word0) && (entry.word1 == item_q.word1) &&
		             (entry.word2 == item_q.word2) && (entry.word3 == item_q.word3);
		age        = item_q.stamp - entry.stamp;
		entry_live = (entry.stamp > item_q.stamp) || (age < TIME_W'(ttl_q));
		entry_hit  = rd_valid_s1 && key_eq && entry_live;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rd_idx_q     <= '0;
			wp_q         <= '0;
			fill_q       <= '0;
			hit_q        <= 1'b0;
			rd_valid_s1  <= 1'b0;
			rd_filled_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_valid_s1  <= ram_re;
			rd_filled_s1 <= CNT_W'(rd_idx_q) < fill_q;
			if (entry_hit) begin
				hit_q <= 1'b1;
			end
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						hit_q    <= 1'b0;
						rd_idx_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_idx_q == IDX_LAST) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (!hit_q) begin
							wp_q <= (wp_q == IDX_LAST) ? '0 : wp_q + IDX_W'(1);
							if (fill_q != FILL_FULL) begin
								fill_q <= fill_q + CNT_W'(1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_q.word0 <= key_word0;
			item_q.word1 <= key_word1;
			item_q.word2 <= key_word2;
			item_q.word3 <= key_word3;
			item_q.stamp <= now_seconds;
		end
		if ((state_q == ST_DONE) && out_free) begin
			accepted_q <= !hit_q;
		end
	end

	assign out_valid = out_valid_q;
	assign accepted  = accepted_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && !paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q <= TTL_RESET;
		end else if (cfg_wr) begin
			ttl_q <= pwdata[TTL_W-1:0];
		end
	end

	assign prdata = paddr[2] ? '0 : APB_DATA_W'(ttl_q);

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the finishing step");

	a_write_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_DONE) && !hit_q && out_free)
		else $error("ring written for a replayed item");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_FULL)
		else $error("fill count beyond ring size");

	a_take_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == ST_SCAN) && (rd_idx_q == '0) && !hit_q)
		else $error("accepted item did not start a scan from entry zero");

endmodule
